/* hw/rtl/snx_pkg.sv */
// Shared constants and helper functions for the 2D simplex noise sampler.
package snx_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int WB            = 30;   // working fraction bits
  localparam int OFS_W         = 34;   // corner offset width
  localparam int SQ_W          = 34;   // scaled square width
  localparam int T_W           = 30;   // falloff width
  localparam int DOT_W         = 36;
  localparam int PART_W        = 37;   // one corner contribution
  localparam int SUM_W         = 39;

  localparam logic [31:0] LCG_MUL  = 32'd1103515245;
  localparam logic [31:0] LCG_INC  = 32'd12345;
  localparam logic [31:0] HASH_MOD = 32'd451958711;
  localparam logic [31:0] SEED_HASH_RST = 32'd12345;  // hash of seed zero

  localparam logic [29:0] F2_W = 30'd393016785;
  localparam logic [27:0] G2_W = 28'd226908346;

  localparam logic signed [15:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [15:0] OUT_MIN = -16'sh8000;

  function automatic logic [31:0] lcg_step(input logic [31:0] v);
    lcg_step = v * LCG_MUL + LCG_INC;
  endfunction

  // Remainder by HASH_MOD; quotient never exceeds nine, compares run side by side.
  function automatic logic [31:0] lat_mod(input logic [31:0] m);
    logic [35:0] kc;
    logic [35:0] r;
    r = 36'(m);
    for (int k = 1; k <= 9; k++) begin
      kc = 36'(k) * 36'(HASH_MOD);
      if (36'(m) >= kc) begin
        r = 36'(m) - kc;
      end
    end
    lat_mod = r[31:0];
  endfunction

  function automatic logic [3:0] grad_code(input logic [2:0] idx);
    logic [3:0] g;
    unique case (idx)
      3'd0: g = 4'hE;
      3'd1: g = 4'h4;
      3'd2: g = 4'hC;
      3'd3: g = 4'h8;
      3'd4: g = 4'hD;
      3'd5: g = 4'h5;
      3'd6: g = 4'hF;
      3'd7: g = 4'hA;
      default: g = 4'hE;
    endcase
    grad_code = g;
  endfunction

endpackage

/* hw/rtl/snx_falloff.sv */
// One corner lane: squared distance, falloff t^4, gradient dot and contribution.
module snx_falloff (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [snx_pkg::OFS_W-1:0]      dx,
  input  logic signed [snx_pkg::OFS_W-1:0]      dy,
  input  logic [3:0]                            code,   // arrives two stages after dx/dy
  output logic signed [snx_pkg::PART_W-1:0]     part
);

  localparam int PW = 2 * snx_pkg::OFS_W;
  localparam int LW = snx_pkg::T_W + 1 + snx_pkg::DOT_W;

  // stage A: squares
  logic [snx_pkg::SQ_W-1:0]         sqx_r, sqy_r, sqx_nxt, sqy_nxt;
  logic signed [snx_pkg::OFS_W-1:0] dxa_r, dya_r;
  // stage B: clamped falloff
  logic [snx_pkg::T_W-1:0]          t_r, t_nxt;
  logic signed [snx_pkg::OFS_W-1:0] dxb_r, dyb_r;
  // stage C: t^2 and dot
  logic [snx_pkg::T_W-1:0]          t2_r, t2_nxt;
  logic signed [snx_pkg::DOT_W-1:0] dotc_r, dot_nxt;
  // stage D: t^4
  logic [snx_pkg::T_W-1:0]          t4_r, t4_nxt;
  logic signed [snx_pkg::DOT_W-1:0] dotd_r;
  // stage E: contribution
  logic signed [snx_pkg::PART_W-1:0] part_r, part_nxt;

  logic signed [PW-1:0]             px, py;
  logic signed [snx_pkg::DOT_W+1:0] tt;
  logic [2*snx_pkg::T_W-1:0]        q2, q4;
  logic signed [LW-1:0]             pl;

  always_comb begin
    px      = PW'(dx) * PW'(dx);
    py      = PW'(dy) * PW'(dy);
    sqx_nxt = snx_pkg::SQ_W'(px >>> snx_pkg::WB);
    sqy_nxt = snx_pkg::SQ_W'(py >>> snx_pkg::WB);

    tt = (snx_pkg::DOT_W+2)'(1) <<< (snx_pkg::WB - 1);
    tt = tt - $signed({4'b0, sqx_r}) - $signed({4'b0, sqy_r});
    t_nxt = (tt > 0) ? tt[snx_pkg::T_W-1:0] : '0;  // non-positive falloff adds nothing

    q2     = (2*snx_pkg::T_W)'(t_r) * (2*snx_pkg::T_W)'(t_r);
    t2_nxt = snx_pkg::T_W'(q2 >> snx_pkg::WB);
    dot_nxt = '0;
    if (code[3]) begin
      dot_nxt = code[1] ? dot_nxt - snx_pkg::DOT_W'(dxb_r) : dot_nxt + snx_pkg::DOT_W'(dxb_r);
    end
    if (|code[2:0]) begin
      dot_nxt = code[0] ? dot_nxt - snx_pkg::DOT_W'(dyb_r) : dot_nxt + snx_pkg::DOT_W'(dyb_r);
    end

    q4     = (2*snx_pkg::T_W)'(t2_r) * (2*snx_pkg::T_W)'(t2_r);
    t4_nxt = snx_pkg::T_W'(q4 >> snx_pkg::WB);

    pl       = $signed(LW'({1'b0, t4_r})) * LW'(dotd_r);
    part_nxt = snx_pkg::PART_W'(pl >>> snx_pkg::WB);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= sqx_nxt;
      sqy_r  <= sqy_nxt;
      dxa_r  <= dx;
      dya_r  <= dy;
      t_r    <= t_nxt;
      dxb_r  <= dxa_r;
      dyb_r  <= dya_r;
      t2_r   <= t2_nxt;
      dotc_r <= dot_nxt;
      t4_r   <= t4_nxt;
      dotd_r <= dotc_r;
      part_r <= part_nxt;
    end
  end

  assign part = part_r;

endmodule

/* hw/rtl/simplex_noise_2d_sample_unit.sv */
// Top level: 2D simplex noise sampler, eleven-stage pipeline.
//
//  port group | dir | contents
//  in_*       | in  | in_valid, in_stall, in_x_coord, in_y_coord (Q16.16)
//  out_*      | out | out_valid, out_stall, out_noise_value (Q1.15)
//  cfg_*      | in  | cfg_we, cfg_wdata (noise seed)
//
// One word enters per cycle unless a stalled result holds the pipeline; the stages are
// (skew, floor, corner hash twice, squares, falloff, t^2 and dot, t^4, contribution, sum, scale).
// After a cfg write the hash of the seed is refreshed through hs_mul_r and then hs_r.
// Synchronous active-low reset clears the valid bits and sets the seed hash to that of seed zero.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
module simplex_noise_2d_sample_unit #(
  parameter int FRAC_BITS = snx_pkg::DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x_coord,
  input  logic signed [31:0] in_y_coord,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_noise_value,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int NSTG  = 11;
  localparam int WB    = snx_pkg::WB;
  localparam int OW    = snx_pkg::OFS_W;
  localparam logic signed [OW-1:0] ONE_W = OW'(1) <<< WB;
  localparam logic signed [OW-1:0] G2_S  = OW'(snx_pkg::G2_W);

  logic [NSTG-1:0] vld_r;
  logic            adv;

  assign adv       = !(vld_r[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // seed hash
  logic [31:0] hs_mul_r, hs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_mul_r <= snx_pkg::SEED_HASH_RST;
      hs_r     <= snx_pkg::SEED_HASH_RST;
    end else begin
      if (cfg_we) begin
        hs_mul_r <= snx_pkg::lcg_step(cfg_wdata);
      end
      hs_r <= snx_pkg::lat_mod(hs_mul_r);
    end
  end

  // stage 1: skew product
  logic signed [31:0] x1_r, y1_r;
  logic signed [63:0] sk_r, sk_nxt;
  logic signed [32:0] sxy;

  // stage 2: cell and fraction
  logic [31:0]          ci_r, cj_r, ci_nxt, cj_nxt;
  logic [FRAC_BITS-1:0] fx_r, fy_r, fx_nxt, fy_nxt;
  logic signed [33:0]   sk;
  logic signed [34:0]   sx, sy;

  // stage 3: unskew product, first hash multiply
  logic [29:0] fxw_r, fyw_r, fxw_nxt, fyw_nxt;
  logic [58:0] up_r, up_nxt;
  logic        di_r, di_nxt;
  logic [31:0] m1_r  [3];
  logic [31:0] m1_nxt[3];
  logic [31:0] cx3_r [3];
  logic [31:0] cx_nxt[3];
  logic [31:0] cy    [3];

  // stage 4: offsets, first hash reduce
  logic signed [OW-1:0] dx_r [3];
  logic signed [OW-1:0] dy_r [3];
  logic signed [OW-1:0] dx_nxt[3];
  logic signed [OW-1:0] dy_nxt[3];
  logic [31:0] h1_r  [3];
  logic [31:0] h1_nxt[3];
  logic [31:0] cx4_r [3];
  logic [28:0] u;
  logic signed [OW-1:0] x0, y0;

  // stage 5 and 6: second hash
  logic [31:0] m2_r  [3];
  logic [31:0] m2_nxt[3];
  logic [3:0]  code_r  [3];
  logic [3:0]  code_nxt[3];
  logic [31:0] h2      [3];

  always_comb begin
    sxy    = 33'(in_x_coord) + 33'(in_y_coord);
    sk_nxt = 64'(sxy) * $signed(64'(snx_pkg::F2_W));

    sk     = 34'(sk_r >>> WB);
    sx     = 35'(x1_r) + 35'(sk);
    sy     = 35'(y1_r) + 35'(sk);
    ci_nxt = 32'(sx >>> FRAC_BITS);
    cj_nxt = 32'(sy >>> FRAC_BITS);
    fx_nxt = sx[FRAC_BITS-1:0];
    fy_nxt = sy[FRAC_BITS-1:0];

    fxw_nxt = 30'(fx_r) << (WB - FRAC_BITS);
    fyw_nxt = 30'(fy_r) << (WB - FRAC_BITS);
    up_nxt  = (59'(fxw_nxt) + 59'(fyw_nxt)) * 59'(snx_pkg::G2_W);
    di_nxt  = fx_r > fy_r;
    // lower triangle steps x first, upper steps y first
    cx_nxt[0] = ci_r;
    cx_nxt[1] = ci_r + 32'(di_nxt);
    cx_nxt[2] = ci_r + 32'd1;
    cy[0]     = cj_r;
    cy[1]     = cj_r + 32'(!di_nxt);
    cy[2]     = cj_r + 32'd1;

    u  = 29'(up_r >> WB);
    x0 = $signed(OW'(fxw_r)) - $signed(OW'(u));
    y0 = $signed(OW'(fyw_r)) - $signed(OW'(u));
    dx_nxt[0] = x0;
    dy_nxt[0] = y0;
    dx_nxt[1] = x0 - (di_r ? ONE_W : '0) + G2_S;
    dy_nxt[1] = y0 - (di_r ? '0 : ONE_W) + G2_S;
    dx_nxt[2] = x0 - ONE_W + (G2_S <<< 1);
    dy_nxt[2] = y0 - ONE_W + (G2_S <<< 1);

    for (int k = 0; k < 3; k++) begin
      m1_nxt[k]   = snx_pkg::lcg_step(cy[k] + hs_r);
      h1_nxt[k]   = snx_pkg::lat_mod(m1_r[k]);
      m2_nxt[k]   = snx_pkg::lcg_step(cx4_r[k] + h1_r[k]);
      h2[k]       = snx_pkg::lat_mod(m2_r[k]);
      code_nxt[k] = snx_pkg::grad_code(h2[k][18:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r  <= in_x_coord;
      y1_r  <= in_y_coord;
      sk_r  <= sk_nxt;
      ci_r  <= ci_nxt;
      cj_r  <= cj_nxt;
      fx_r  <= fx_nxt;
      fy_r  <= fy_nxt;
      fxw_r <= fxw_nxt;
      fyw_r <= fyw_nxt;
      up_r  <= up_nxt;
      di_r  <= di_nxt;
      for (int k = 0; k < 3; k++) begin
        m1_r[k]   <= m1_nxt[k];
        cx3_r[k]  <= cx_nxt[k];
        dx_r[k]   <= dx_nxt[k];
        dy_r[k]   <= dy_nxt[k];
        h1_r[k]   <= h1_nxt[k];
        cx4_r[k]  <= cx3_r[k];
        m2_r[k]   <= m2_nxt[k];
        code_r[k] <= code_nxt[k];
      end
    end
  end

  // corner lanes, stages 5 to 9
  logic signed [snx_pkg::PART_W-1:0] part[3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    snx_falloff u_lane (
      .clk  (clk),
      .en   (adv),
      .dx   (dx_r[g]),
      .dy   (dy_r[g]),
      .code (code_r[g]),
      .part (part[g])
    );
  end

  // stage 10: sum, stage 11: scale by 70, round, saturate
  logic signed [snx_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic signed [15:0]               res_r, res_nxt;
  logic signed [45:0]               sc;
  logic signed [30:0]               rr;

  always_comb begin
    sum_nxt = snx_pkg::SUM_W'(part[0]) + snx_pkg::SUM_W'(part[1])
            + snx_pkg::SUM_W'(part[2]);
    sc = 46'(sum_r) * 46'sd70 + 46'sd16384;
    rr = 31'(sc >>> (WB - 15));
    if (rr > 31'(snx_pkg::OUT_MAX)) begin
      res_nxt = snx_pkg::OUT_MAX;
    end else if (rr < 31'(snx_pkg::OUT_MIN)) begin
      res_nxt = snx_pkg::OUT_MIN;
    end else begin
      res_nxt = 16'(rr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum_r <= sum_nxt;
      res_r <= res_nxt;
    end
  end

  assign out_noise_value = res_r;

endmodule
